@@ sv/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the path smoother
// lane geometry, fixed-point constants, the control and queue entry records
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int MAX_DIMS    = 8;
   localparam int COORD_BITS  = 24;
   localparam int FACTOR_BITS = 17;
   localparam int DIMS_BITS   = 4;

   // accumulator holds the three-tap sum scaled by 2^17
   localparam int ACC_BITS    = COORD_BITS + 19;
   localparam int FRAC_SHIFT  = 17;

   localparam logic [FACTOR_BITS-1:0] Q_ONE = FACTOR_BITS'(65536);

   // output queue between the lanes and the result channel
   localparam int QUEUE_DEPTH = 3;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef coord_type [MAX_DIMS-1:0]     image_type;

   // which image feeds the first result of a request
   typedef enum logic {
      SRC_SMOOTHED,
      SRC_RAW
   } src_type;

   // images of the current path held in the window
   typedef enum logic [1:0] {
      HELD_NONE,
      HELD_ONE,
      HELD_TWO
   } held_type;

   typedef struct packed {
      logic    valid;
      src_type src;
      logic    two;     // request emits a second result (raw last image)
      logic    end_a;   // first result is the end of the path
   } ctrl_type;

   typedef struct packed {
      image_type img_a;
      image_type img_b;
      logic      two;
      logic      end_a;
   } entry_type;

endpackage

@@ sv/pts_lane.sv @@
// ----------------------------------------------------------------------------
// pts_lane: one coordinate lane of the three-tap smoother
// registered weight products, then round half up and saturate
// ----------------------------------------------------------------------------
module pts_lane import pts_pkg::*; (
   input  logic                   clock,
   input  logic                   load,
   input  logic [FACTOR_BITS-1:0] factor,
   input  coord_type              prev_coord,
   input  coord_type              mid_coord,
   input  coord_type              next_coord,
   output coord_type              smoothed
);

   logic signed [ACC_BITS-1:0] near_prod_ff, near_prod_in;
   logic signed [ACC_BITS-1:0] mid_prod_ff, mid_prod_in;
   logic signed [ACC_BITS-1:0] near_sum, factor_ext, mid_weight_ext, mid_ext;
   logic signed [ACC_BITS-1:0] acc, shifted;
   logic [FACTOR_BITS-1:0]     mid_weight;
   logic [ACC_BITS-COORD_BITS:0] upper;

   // stage one: a*(prev+next) and 2*(1-a)*cur
   always_comb begin
      mid_weight     = Q_ONE - factor;
      near_sum       = ACC_BITS'($signed(prev_coord)) + ACC_BITS'($signed(next_coord));
      factor_ext     = $signed(ACC_BITS'(factor));
      mid_weight_ext = $signed(ACC_BITS'({mid_weight, 1'b0}));
      mid_ext        = ACC_BITS'($signed(mid_coord));
      near_prod_in   = factor_ext * near_sum;
      mid_prod_in    = mid_weight_ext * mid_ext;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         near_prod_ff <= near_prod_in;
         mid_prod_ff  <= mid_prod_in;
      end
   end

   // stage two: add half an lsb, drop the fraction, clamp to coordinate range
   always_comb begin
      acc     = near_prod_ff + mid_prod_ff + $signed(ACC_BITS'(Q_ONE));
      shifted = acc >>> FRAC_SHIFT;
      upper   = shifted[ACC_BITS-1:COORD_BITS-1];
      if ((&upper) || !(|upper)) begin
         smoothed = shifted[COORD_BITS-1:0];
      end else if (shifted[ACC_BITS-1]) begin
         smoothed = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         smoothed = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
   end

endmodule

@@ sv/pts_merge.sv @@
// ----------------------------------------------------------------------------
// pts_merge: merging stage of the lanes
// picks smoothed or raw image per request and zeroes unused lanes
// ----------------------------------------------------------------------------
module pts_merge import pts_pkg::*; (
   input  ctrl_type             ctrl,
   input  image_type            lane_out,
   input  image_type            raw_a,
   input  image_type            raw_b,
   input  logic [DIMS_BITS-1:0] active_dims,
   output logic                 push,
   output entry_type            entry
);

   always_comb begin
      push        = ctrl.valid;
      entry.two   = ctrl.two;
      entry.end_a = ctrl.end_a;
      for (int j = 0; j < MAX_DIMS; j++) begin
         if (DIMS_BITS'(j) < active_dims) begin
            entry.img_a[j] = (ctrl.src == SRC_SMOOTHED) ? lane_out[j] : raw_a[j];
            entry.img_b[j] = raw_b[j];
         end else begin
            entry.img_a[j] = '0;
            entry.img_b[j] = '0;
         end
      end
   end

endmodule

@@ sv/pts_out_queue.sv @@
// ----------------------------------------------------------------------------
// pts_out_queue: result queue of the smoother
// holds up to QUEUE_DEPTH requests and plays out one or two results each
// ----------------------------------------------------------------------------
module pts_out_queue import pts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  entry_type           entry,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output image_type           rsp_image,
   output logic                rsp_end,
   output logic                rsp_last,
   output logic [CNT_BITS-1:0] count
);

   entry_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                phase_ff, phase_in;
   logic                fire, last_piece, pop;
   entry_type           head_entry;

   always_comb begin
      head_entry = entries_ff[head_ff];
      rsp_valid  = (count_ff != '0);
      fire       = rsp_valid && !rsp_stall;
      last_piece = !head_entry.two || phase_ff;
      pop        = fire && last_piece;

      if (phase_ff) begin
         rsp_image = head_entry.img_b;
         rsp_end   = 1'b1;
         rsp_last  = 1'b1;
      end else begin
         rsp_image = head_entry.img_a;
         rsp_end   = head_entry.end_a;
         rsp_last  = !head_entry.two;
      end

      phase_in = fire ? !last_piece : phase_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (pop) begin
         head_in = (head_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      count_in = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
      count    = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= entry;
      end
   end

endmodule

@@ sv/path_three_tap_smoother_unit.sv @@
// ----------------------------------------------------------------------------
// path_three_tap_smoother_unit: three-tap smoothing of a path of images
// Usage: requests carry one image of eight signed Q8.16 coordinates and a
// final_image flag. Interior images come out as 0.5a*prev + (1-a)*cur +
// 0.5a*next, rounded and saturated; first and last images pass raw. Results
// lag one image in paths of two or more; their last image releases two results.
// Channels: req_* in, rsp_* out, valid/stall each, csr_* APB-style setup.
// A result passes the lane stage register and then the result queue before
// it can be accepted.
// Throughput: one request per cycle while each yields at most one result and
// rsp_stall stays low; a path end's two results share the single result port.
// The input stalls when the three-entry result queue plus the request in the
// lane stage would fill it.
// Reset: empties the window and the queue, smooth_factor 0, active_dims 8.
// Receiver stall: results wait in the queue; requests keep flowing until the
// queue and the request in the lane stage fill it, then req_stall rises.
// ----------------------------------------------------------------------------
module path_three_tap_smoother_unit import pts_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_stall,
   input  coord_type       req_in_c0,
   input  coord_type       req_in_c1,
   input  coord_type       req_in_c2,
   input  coord_type       req_in_c3,
   input  coord_type       req_in_c4,
   input  coord_type       req_in_c5,
   input  coord_type       req_in_c6,
   input  coord_type       req_in_c7,
   input  logic            req_final_image,
   // result channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output coord_type       rsp_out_c0,
   output coord_type       rsp_out_c1,
   output coord_type       rsp_out_c2,
   output coord_type       rsp_out_c3,
   output coord_type       rsp_out_c4,
   output coord_type       rsp_out_c5,
   output coord_type       rsp_out_c6,
   output coord_type       rsp_out_c7,
   output logic            rsp_end_of_path,
   output logic            rsp_last_of_run,
   // configuration port
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   // register index, taken from the word address bit
   localparam logic CSR_IDX_FACTOR = 1'b0;
   localparam logic CSR_IDX_DIMS   = 1'b1;

   // configuration registers
   logic [FACTOR_BITS-1:0] smooth_factor_ff;
   logic [DIMS_BITS-1:0]   active_dims_ff;
   logic [FACTOR_BITS-1:0] factor_clamped;
   logic                   csr_write;

   // window of held images
   held_type  held_ff, held_in;
   image_type older_ff, older_in;
   image_type newer_ff, newer_in;
   image_type req_image;

   // lane stage control and raw images
   ctrl_type  ctrl_ff, ctrl_in;
   image_type raw_a_ff, raw_a_in;
   image_type raw_b_ff, raw_b_in;

   logic                req_fire;
   image_type           lane_out;
   logic                push;
   entry_type           entry;
   image_type           rsp_image;
   logic [CNT_BITS-1:0] queue_count;

   // ------------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_FACTOR: csr_prdata = 32'(smooth_factor_ff);
         CSR_IDX_DIMS:   csr_prdata = 32'(active_dims_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_factor_ff <= '0;
         active_dims_ff   <= DIMS_BITS'(MAX_DIMS);
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_FACTOR) begin
            smooth_factor_ff <= csr_pwdata[FACTOR_BITS-1:0];
         end else begin
            active_dims_ff <= csr_pwdata[DIMS_BITS-1:0];
         end
      end
   end

   // factors above 1.0 act as 1.0
   assign factor_clamped = (smooth_factor_ff > Q_ONE) ? Q_ONE : smooth_factor_ff;

   // ------------------------------------------------------------------------
   // request intake
   // ------------------------------------------------------------------------
   assign req_image[0] = req_in_c0;
   assign req_image[1] = req_in_c1;
   assign req_image[2] = req_in_c2;
   assign req_image[3] = req_in_c3;
   assign req_image[4] = req_in_c4;
   assign req_image[5] = req_in_c5;
   assign req_image[6] = req_in_c6;
   assign req_image[7] = req_in_c7;

   // stall once the queue could not take everything in flight
   assign req_stall = ({1'b0, queue_count} + (CNT_BITS + 1)'(ctrl_ff.valid))
                      >= (CNT_BITS + 1)'(QUEUE_DEPTH);
   assign req_fire  = req_valid && !req_stall;

   // window next state: a path end empties it, otherwise it slides
   always_comb begin
      held_in  = held_ff;
      older_in = older_ff;
      newer_in = newer_ff;
      if (req_fire) begin
         case (held_ff)
            HELD_NONE: begin
               if (!req_final_image) begin
                  newer_in = req_image;
                  held_in  = HELD_ONE;
               end
            end
            default: begin
               if (req_final_image) begin
                  held_in = HELD_NONE;
               end else begin
                  older_in = newer_ff;
                  newer_in = req_image;
                  held_in  = HELD_TWO;
               end
            end
         endcase
      end
   end

   // lane stage control: what each request releases
   always_comb begin
      ctrl_in   = '0;
      raw_a_in  = raw_a_ff;
      raw_b_in  = raw_b_ff;
      if (req_fire) begin
         raw_b_in      = req_image;
         ctrl_in.two   = req_final_image;
         ctrl_in.end_a = 1'b0;
         case (held_ff)
            HELD_NONE: begin
               // a single-image path comes out at once
               ctrl_in.valid = req_final_image;
               ctrl_in.src   = SRC_RAW;
               ctrl_in.two   = 1'b0;
               ctrl_in.end_a = 1'b1;
               raw_a_in      = req_image;
            end
            HELD_ONE: begin
               // first image of the path passes raw
               ctrl_in.valid = 1'b1;
               ctrl_in.src   = SRC_RAW;
               raw_a_in      = newer_ff;
            end
            default: begin
               ctrl_in.valid = 1'b1;
               ctrl_in.src   = SRC_SMOOTHED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
         ctrl_ff <= '0;
      end else begin
         held_ff <= held_in;
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      older_ff <= older_in;
      newer_ff <= newer_in;
      raw_a_ff <= raw_a_in;
      raw_b_ff <= raw_b_in;
   end

   // ------------------------------------------------------------------------
   // coordinate lanes: prev = older, cur = newer, next = incoming image
   // ------------------------------------------------------------------------
   for (genvar j = 0; j < MAX_DIMS; j++) begin : g_lane
      pts_lane u_lane (
         .clock      (clock),
         .load       (req_fire),
         .factor     (factor_clamped),
         .prev_coord (older_ff[j]),
         .mid_coord  (newer_ff[j]),
         .next_coord (req_image[j]),
         .smoothed   (lane_out[j])
      );
   end

   // merge lane results into one queue entry
   pts_merge u_merge (
      .ctrl        (ctrl_ff),
      .lane_out    (lane_out),
      .raw_a       (raw_a_ff),
      .raw_b       (raw_b_ff),
      .active_dims (active_dims_ff),
      .push        (push),
      .entry       (entry)
   );

   // result queue and output sequencing
   pts_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry     (entry),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_image (rsp_image),
      .rsp_end   (rsp_end_of_path),
      .rsp_last  (rsp_last_of_run),
      .count     (queue_count)
   );

   assign rsp_out_c0 = rsp_image[0];
   assign rsp_out_c1 = rsp_image[1];
   assign rsp_out_c2 = rsp_image[2];
   assign rsp_out_c3 = rsp_image[3];
   assign rsp_out_c4 = rsp_image[4];
   assign rsp_out_c5 = rsp_image[5];
   assign rsp_out_c6 = rsp_image[6];
   assign rsp_out_c7 = rsp_image[7];

endmodule

@@ test/path_smoother_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_smoother_check_pkg: expected-result tracking for the path smoother
// Holds a sliding window of the last two images of the current path and
// predicts the smoothed and raw images each request releases, then compares
// them in order against what the result channel delivers.
// ----------------------------------------------------------------------------
package path_smoother_check_pkg;
   import pts_pkg::*;

   localparam int REG_SMOOTH_FACTOR = 0;
   localparam int REG_ACTIVE_DIMS   = 1;

   localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   typedef struct packed {
      image_type coords;
      logic      end_of_path;
      logic      last_of_run;
   } path_point_type;

   class path_smoother_checker_type;
      logic [FACTOR_BITS-1:0] factor;
      logic [DIMS_BITS-1:0]   dims;
      image_type              older;
      image_type              newer;
      held_type               held;
      path_point_type         pending_points[$];
      int                     mismatches;

      function new();
         factor     = '0;
         dims       = DIMS_BITS'(MAX_DIMS);
         older      = '0;
         newer      = '0;
         held       = HELD_NONE;
         mismatches = 0;
      endfunction

      function void write_register(int index, logic [31:0] value);
         if (index == REG_SMOOTH_FACTOR) begin
            factor = value[FACTOR_BITS-1:0];
         end else if (index == REG_ACTIVE_DIMS) begin
            dims = value[DIMS_BITS-1:0];
         end
      endfunction

      function int pending();
         return pending_points.size();
      endfunction

      // 0.5a*prev + (1-a)*cur + 0.5a*next, sum kept scaled by 2^17
      function coord_type smooth_coord(coord_type prev, coord_type cur, coord_type next);
         longint a;
         longint acc;
         longint r;
         a   = (factor > Q_ONE) ? longint'(Q_ONE) : longint'(factor);
         acc = a * (longint'(prev) + longint'(next))
             + 2 * (longint'(Q_ONE) - a) * longint'(cur);
         r   = (acc + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
         if (r > COORD_MAX) begin
            r = COORD_MAX;
         end else if (r < COORD_MIN) begin
            r = COORD_MIN;
         end
         return coord_type'(r);
      endfunction

      function void push_point(image_type img, logic end_p, logic last_r);
         path_point_type p;
         int             lanes;
         lanes = (dims > MAX_DIMS) ? MAX_DIMS : int'(dims);
         for (int j = 0; j < MAX_DIMS; j++) begin
            p.coords[j] = (j < lanes) ? img[j] : '0;
         end
         p.end_of_path = end_p;
         p.last_of_run = last_r;
         pending_points = {pending_points, p};
      endfunction

      function void note_image(image_type img, logic fin);
         image_type sm;
         case (held)
            HELD_NONE: begin
               if (fin) begin
                  push_point(img, 1'b1, 1'b1);
               end else begin
                  newer = img;
                  held  = HELD_ONE;
               end
            end
            HELD_ONE: begin
               // first image of the path passes raw
               if (fin) begin
                  push_point(newer, 1'b0, 1'b0);
                  push_point(img, 1'b1, 1'b1);
                  held = HELD_NONE;
               end else begin
                  push_point(newer, 1'b0, 1'b1);
                  older = newer;
                  newer = img;
                  held  = HELD_TWO;
               end
            end
            default: begin
               for (int j = 0; j < MAX_DIMS; j++) begin
                  sm[j] = smooth_coord(older[j], newer[j], img[j]);
               end
               if (fin) begin
                  push_point(sm, 1'b0, 1'b0);
                  push_point(img, 1'b1, 1'b1);
                  held = HELD_NONE;
               end else begin
                  push_point(sm, 1'b0, 1'b1);
                  older = newer;
                  newer = img;
                  held  = HELD_TWO;
               end
            end
         endcase
      endfunction

      function void report(string what, longint want, longint got);
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         mismatches++;
      endfunction

      function void check_point(path_point_type got);
         path_point_type want;
         if (pending_points.size() == 0) begin
            report("unexpected result, pending count", 0, 1);
            return;
         end
         want = pending_points.pop_front();
         for (int j = 0; j < MAX_DIMS; j++) begin
            if (got.coords[j] !== want.coords[j]) begin
               report($sformatf("out_c%0d", j), longint'($signed(want.coords[j])),
                      longint'($signed(got.coords[j])));
            end
         end
         if (got.end_of_path !== want.end_of_path) begin
            report("end_of_path", want.end_of_path, got.end_of_path);
         end
         if (got.last_of_run !== want.last_of_run) begin
            report("last_of_run", want.last_of_run, got.last_of_run);
         end
      endfunction
   endclass

endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the three-tap path smoother
// Streams paths of images through the request channel under several smoothing
// factors and lane counts, with random sender gaps and receiver stalls, and
// checks every result against a running prediction of the smoothing window.
// ----------------------------------------------------------------------------
module tb_top;
   import pts_pkg::*;
   import path_smoother_check_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   // request side
   logic        req_valid = 1'b0;
   wire         req_stall;
   image_type   req_image = '0;
   logic        req_final_image = 1'b0;

   // result side
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire image_type rsp_image;
   wire         rsp_end_of_path;
   wire         rsp_last_of_run;

   // register port
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   // idling rates in percent, changed between phases
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   path_smoother_checker_type expected_path = new();

   path_three_tap_smoother_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_c0       (req_image[0]),
      .req_in_c1       (req_image[1]),
      .req_in_c2       (req_image[2]),
      .req_in_c3       (req_image[3]),
      .req_in_c4       (req_image[4]),
      .req_in_c5       (req_image[5]),
      .req_in_c6       (req_image[6]),
      .req_in_c7       (req_image[7]),
      .req_final_image (req_final_image),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_c0      (rsp_image[0]),
      .rsp_out_c1      (rsp_image[1]),
      .rsp_out_c2      (rsp_image[2]),
      .rsp_out_c3      (rsp_image[3]),
      .rsp_out_c4      (rsp_image[4]),
      .rsp_out_c5      (rsp_image[5]),
      .rsp_out_c6      (rsp_image[6]),
      .rsp_out_c7      (rsp_image[7]),
      .rsp_end_of_path (rsp_end_of_path),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // receiver stall, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // every accepted result goes against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         expected_path.check_point(path_point_type'{rsp_image, rsp_end_of_path,
                                                    rsp_last_of_run});
      end
   end

   // all lanes set to one value
   function automatic image_type fill(longint v);
      image_type img;
      for (int j = 0; j < MAX_DIMS; j++) begin
         img[j] = coord_type'(v);
      end
      return img;
   endfunction

   // extremes and values near zero show up far more often than uniform draws give
   function automatic coord_type random_coord();
      case ($urandom_range(7))
         0:       return coord_type'(COORD_MAX);
         1:       return coord_type'(COORD_MIN);
         2:       return coord_type'(int'($urandom_range(8)) - 4);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic image_type random_image();
      image_type img;
      for (int j = 0; j < MAX_DIMS; j++) begin
         img[j] = random_coord();
      end
      return img;
   endfunction

   function automatic logic [31:0] random_factor();
      if ($urandom_range(1) == 0) begin
         return 32'($urandom_range(0, 65536));
      end
      return 32'($urandom_range(0, 131071));
   endfunction

   // register write followed by a read back of the same register
   task automatic write_csr(int index, logic [31:0] value);
      logic [31:0] mask;
      mask = (index == REG_SMOOTH_FACTOR) ? 32'((1 << FACTOR_BITS) - 1)
                                          : 32'((1 << DIMS_BITS) - 1);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(4 * index);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      expected_path.write_register(index, value);
      // read setup, psel stays high
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (value & mask)) begin
         expected_path.report($sformatf("register %0d read back", index),
                              longint'(value & mask), longint'(csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one request; valid stays high when the next request follows at once
   task automatic send_image(image_type img, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_image       <= img;
      req_final_image <= fin;
      do @(posedge clock); while (req_stall);
      expected_path.note_image(img, fin);
   endtask

   // drain all results, then wait for the lane stage to empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_path.pending() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // whole paths with random content; mostly short to mid length, a few long
   task automatic run_paths(int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(3))
            0:       len = $urandom_range(1, 3);
            1, 2:    len = $urandom_range(4, 24);
            default: len = ($urandom_range(9) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(4, 12);
         endcase
         for (int i = 1; i <= len; i++) begin
            send_image(random_image(), i == len);
         end
         sent += len;
      end
   endtask

   task automatic run_phase(logic [31:0] factor, logic [31:0] dims, int idle_pct,
                            int stall_pct, int n_items);
      write_csr(REG_SMOOTH_FACTOR, factor);
      write_csr(REG_ACTIVE_DIMS, dims);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      run_paths(n_items);
      settle();
   endtask

   initial begin
      image_type ties;
      ties = '{coord_type'(5), coord_type'(0), coord_type'(COORD_MIN),
               coord_type'(COORD_MAX), coord_type'(-3), coord_type'(3),
               coord_type'(-1), coord_type'(1)};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: factor zero keeps interior images, all eight lanes live
      send_image(fill(COORD_MAX), 1'b0);
      send_image(fill(COORD_MIN), 1'b0);
      send_image(ties, 1'b0);
      send_image(fill(0), 1'b1);
      settle();

      // full smoothing: interior is the mean of its neighbors, ties round up
      write_csr(REG_SMOOTH_FACTOR, 32'd65536);
      write_csr(REG_ACTIVE_DIMS, 32'd8);
      send_image(ties, 1'b0);
      send_image(fill(COORD_MIN), 1'b0);
      send_image(fill(0), 1'b0);
      send_image(fill(COORD_MAX), 1'b0);
      send_image(fill(COORD_MIN), 1'b1);
      // single-image path, then two-image path
      send_image(fill(COORD_MAX), 1'b1);
      send_image(fill(-1), 1'b0);
      send_image(fill(1), 1'b1);
      settle();

      // out-of-range factor and lane count saturate to their maximum
      write_csr(REG_SMOOTH_FACTOR, 32'd131071);
      write_csr(REG_ACTIVE_DIMS, 32'd15);
      send_image(ties, 1'b0);
      send_image(fill(COORD_MAX), 1'b0);
      send_image(fill(0), 1'b1);
      settle();

      // no lanes live: every coordinate reads zero
      write_csr(REG_SMOOTH_FACTOR, 32'd1);
      write_csr(REG_ACTIVE_DIMS, 32'd0);
      for (int i = 1; i <= 3; i++) begin
         send_image(random_image(), i == 3);
      end
      settle();

      // a single live lane
      write_csr(REG_SMOOTH_FACTOR, 32'd32768);
      write_csr(REG_ACTIVE_DIMS, 32'd1);
      for (int i = 1; i <= 3; i++) begin
         send_image(random_image(), i == 3);
      end
      settle();

      // random paths across settings and idling patterns
      run_phase(32'd32768, 32'd8, 0, 0, 300);
      run_phase(random_factor(), 32'($urandom_range(1, 8)), 80, 0, 300);
      run_phase(32'd65536, 32'd8, 0, 80, 300);
      run_phase(random_factor(), 32'($urandom_range(0, 15)), 18, 18, 300);
      run_phase(32'd131071, 32'd15, 0, 0, 150);
      run_phase(random_factor(), 32'($urandom_range(1, 8)), 18, 18, 400);

      repeat (8) @(posedge clock);
      if (expected_path.mismatches == 0 && expected_path.pending() == 0) begin
         $display("path_three_tap_smoother_unit verification clean");
      end else begin
         $display("path_three_tap_smoother_unit verification failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("path_three_tap_smoother_unit verification failed");
      $finish;
   end

endmodule
